>>> rtl/swssu_pkg.sv
// Shared types and constants for the sliding window speed statistic unit.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package swssu_pkg;

  // Payload widths.
  localparam int unsigned SpeedW  = 24;
  localparam int unsigned HeightW = 25;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgWindowFrames = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStatMethod   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgUseFullSpeed = 2'd2;

  // Statistic selection codes.
  localparam logic [1:0] MethodAvg       = 2'd0;
  localparam logic [1:0] MethodMaxSpeed  = 2'd1;
  localparam logic [1:0] MethodMaxHeight = 2'd2;
  localparam logic [1:0] MethodMinSpeed  = 2'd3;

  // Default ring depth.
  localparam int unsigned DefWindowDepth = 256;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StTail,
    StFin,
    StDiv,
    StDone
  } state_e;

endpackage

`default_nettype wire

>>> rtl/swssu_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module swssu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/swssu_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module swssu_div #(
  parameter int unsigned DividendW = 32,
  parameter int unsigned DivisorW  = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic      [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = (DividendW > 1) ? $clog2(DividendW) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(DividendW - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  div_q, div_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW:0]    rem_sh;
  logic [DivisorW:0]    rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, quo_q[DividendW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = (rem_sh >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DivisorW-1:0] : rem_sh[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/sliding_window_speed_statistic_unit.sv
// Top level of the sliding window speed statistic unit: control sequencer,
// scan datapath and output register. Uses swssu_pkg, swssu_ram and swssu_div.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    speed_planar_i, speed_full_i, height_i
// out       source     out_valid_o / out_stall_i  window_speed_o
// cfg       sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item occupies the unit while its clamped window of N entries is read
// through the single read port of the sample RAM (one entry a cycle) and,
// for the average, while the bit-serial divider runs.
// Reset clears all control state at once; the RAM is not swept. A full flag
// and the write pointer tell written entries from unwritten ones, which read
// as zero. A finished result waits in the output register while the next
// item is already taken in; only a second result blocks on a stalled output.

module sliding_window_speed_statistic_unit #(
  parameter int unsigned WINDOW_DEPTH = swssu_pkg::DefWindowDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [swssu_pkg::SpeedW-1:0]    speed_planar_i,
  input  wire logic [swssu_pkg::SpeedW-1:0]    speed_full_i,
  input  wire logic signed [swssu_pkg::HeightW-1:0] height_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [swssu_pkg::SpeedW-1:0]    window_speed_o,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [swssu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [swssu_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  import swssu_pkg::*;

  localparam int unsigned AddrW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SumW   = SpeedW + AddrW;
  localparam int unsigned EntryW = SpeedW + HeightW;

  localparam logic [AddrW-1:0]  LastAddr = AddrW'(WINDOW_DEPTH - 1);
  localparam logic [AddrW:0]    DepthExt = (AddrW + 1)'(WINDOW_DEPTH);
  localparam logic [CfgDataW:0] DepthCfg = (CfgDataW + 1)'(WINDOW_DEPTH);

  // Sequencer state and configuration.
  state_e state_q, state_d;
  logic [CfgDataW-1:0] frames_q, frames_d;
  logic [1:0]          method_q, method_d;
  logic                full_speed_q, full_speed_d;

  // Ring bookkeeping.
  logic [AddrW-1:0] wp_q, wp_d;
  logic             full_q, full_d;

  // Scan control.
  logic [AddrW-1:0] n_q, n_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] iss_q, iss_d;
  logic             rd_pend_q, rd_pend_d;
  logic             ent_ok_q, ent_ok_d;
  logic             first_q, first_d;

  // Accumulators and result.
  logic [SumW-1:0]           sum_q, sum_d;
  logic [SpeedW-1:0]         best_spd_q, best_spd_d;
  logic signed [HeightW-1:0] best_h_q, best_h_d;
  logic [SpeedW-1:0]         res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic [SpeedW-1:0]         out_speed_q, out_speed_d;

  // Sequencer outputs.
  logic ram_re;
  logic div_start;
  logic out_free;
  logic accept;

  // Datapath helpers.
  logic [AddrW-1:0]          n_clamp;
  logic [AddrW-1:0]          wp_next;
  logic [AddrW:0]            start_diff;
  logic [AddrW:0]            start_wrap;
  logic [AddrW-1:0]          pos_start;
  logic [AddrW-1:0]          pos_next;
  logic [EntryW-1:0]         ram_wdata;
  logic [EntryW-1:0]         ram_rdata;
  logic [SpeedW-1:0]         rd_spd;
  logic signed [HeightW-1:0] rd_h;
  logic                      div_done;
  logic [SumW-1:0]           div_quo;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Window length clamped to 1 .. WINDOW_DEPTH-1.
  always_comb begin
    if (frames_q == '0) begin
      n_clamp = AddrW'(1);
    end else if ({1'b0, frames_q} >= DepthCfg) begin
      n_clamp = LastAddr;
    end else begin
      n_clamp = frames_q[AddrW-1:0];
    end
  end

  assign wp_next    = (wp_q == LastAddr) ? '0 : wp_q + AddrW'(1);
  assign start_diff = {1'b0, wp_next} - {1'b0, n_clamp};
  assign start_wrap = start_diff + DepthExt;
  assign pos_start  = start_diff[AddrW] ? start_wrap[AddrW-1:0] : start_diff[AddrW-1:0];
  assign pos_next   = (pos_q == LastAddr) ? '0 : pos_q + AddrW'(1);

  assign ram_wdata = {height_i, full_speed_q ? speed_full_i : speed_planar_i};

  // Entries never written since reset read as zero samples.
  assign rd_spd = ent_ok_q ? ram_rdata[SpeedW-1:0] : '0;
  assign rd_h   = ent_ok_q ? $signed(ram_rdata[EntryW-1:SpeedW]) : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (iss_q == n_q - AddrW'(1)) begin
          state_d = StTail;
        end
      end
      StTail: begin
        state_d = StFin;
      end
      StFin: begin
        state_d = (method_q == MethodAvg) ? StDiv : StDone;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      StIdle: in_stall_o = 1'b0;
      StScan: ram_re = 1'b1;
      StTail: ;
      StFin:  div_start = (method_q == MethodAvg);
      StDiv:  ;
      StDone: ;
      default: ;
    endcase
  end

  // Datapath and configuration next values.
  always_comb begin
    frames_d     = frames_q;
    method_d     = method_q;
    full_speed_d = full_speed_q;
    wp_d         = wp_q;
    full_d       = full_q;
    n_d          = n_q;
    pos_d        = pos_q;
    iss_d        = iss_q;
    rd_pend_d    = ram_re;
    ent_ok_d     = ent_ok_q;
    first_d      = first_q;
    sum_d        = sum_q;
    best_spd_d   = best_spd_q;
    best_h_d     = best_h_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_speed_d  = out_speed_q;

    // Configuration must only change while the unit is idle; the block does not enforce this.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowFrames: frames_d = cfg_wdata_i;
        CfgStatMethod:   method_d = cfg_wdata_i[1:0];
        CfgUseFullSpeed: full_speed_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    // New sample: advance the write pointer and set up the scan.
    if (accept) begin
      wp_d    = wp_next;
      full_d  = full_q || (wp_q == LastAddr);
      n_d     = n_clamp;
      pos_d   = pos_start;
      iss_d   = '0;
      first_d = 1'b1;
      sum_d   = '0;
    end

    // Issue one read per cycle, oldest entry first.
    if (ram_re) begin
      pos_d    = pos_next;
      iss_d    = iss_q + AddrW'(1);
      ent_ok_d = full_q || (pos_q < wp_q);
    end

    // Fold in the entry read in the previous cycle.
    if (rd_pend_q) begin
      first_d = 1'b0;
      sum_d   = sum_q + SumW'(rd_spd);
      unique case (method_q)
        MethodMaxSpeed: begin
          if (first_q || rd_spd > best_spd_q) begin
            best_spd_d = rd_spd;
          end
        end
        MethodMaxHeight: begin
          if (first_q || rd_h > best_h_q) begin
            best_spd_d = rd_spd;
            best_h_d   = rd_h;
          end
        end
        MethodMinSpeed: begin
          if (first_q || rd_spd < best_spd_q) begin
            best_spd_d = rd_spd;
          end
        end
        default: ;
      endcase
    end

    if (state_q == StFin && method_q != MethodAvg) begin
      res_d = best_spd_q;
    end
    // The average never exceeds the largest sample, so the low bits hold it.
    if (state_q == StDiv && div_done) begin
      res_d = div_quo[SpeedW-1:0];
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == StDone && out_free) begin
      out_valid_d = 1'b1;
      out_speed_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      frames_q     <= CfgDataW'(1);
      method_q     <= MethodAvg;
      full_speed_q <= 1'b0;
      wp_q         <= '0;
      full_q       <= 1'b0;
      n_q          <= AddrW'(1);
      pos_q        <= '0;
      iss_q        <= '0;
      rd_pend_q    <= 1'b0;
      ent_ok_q     <= 1'b0;
      first_q      <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      frames_q     <= frames_d;
      method_q     <= method_d;
      full_speed_q <= full_speed_d;
      wp_q         <= wp_d;
      full_q       <= full_d;
      n_q          <= n_d;
      pos_q        <= pos_d;
      iss_q        <= iss_d;
      rd_pend_q    <= rd_pend_d;
      ent_ok_q     <= ent_ok_d;
      first_q      <= first_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= sum_d;
    best_spd_q  <= best_spd_d;
    best_h_q    <= best_h_d;
    res_q       <= res_d;
    out_speed_q <= out_speed_d;
  end

  // Speed and height samples share one RAM word.
  swssu_ram #(
    .Width (EntryW),
    .Depth (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  swssu_div #(
    .DividendW (SumW),
    .DivisorW  (AddrW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o    = out_valid_q;
  assign window_speed_o = out_speed_q;

endmodule

`default_nettype wire

>>> test/sliding_window_speed_statistic_unit_tb.sv
// Self-checking testbench for the sliding window speed statistic unit: directed
// and random samples checked against an in-bench window statistic predictor.
// Depends on swssu_pkg and the sliding_window_speed_statistic_unit RTL only.
module sliding_window_speed_statistic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swssu_pkg::*;

  localparam int unsigned RingDepth = DefWindowDepth;
  localparam int unsigned PtrW = $clog2(RingDepth);
  // Cycles without any transfer before the run is declared hung. The limit leaves
  // room for the slowest item (average over 255 entries) plus output stalls.
  localparam int unsigned HangLimit = 20000;
  // Worst-case item latency, waited out once at the very end.
  localparam int unsigned EndSettle = 300;
  localparam int unsigned PhaseSettle = 8;

  localparam logic signed [HeightW-1:0] HeightMax = {1'b0, {(HeightW-1){1'b1}}};
  localparam logic signed [HeightW-1:0] HeightMin = {1'b1, {(HeightW-1){1'b0}}};
  localparam logic [SpeedW-1:0] SpeedMax = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SpeedW-1:0] speed_planar_i = '0;
  logic [SpeedW-1:0] speed_full_i = '0;
  logic signed [HeightW-1:0] height_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SpeedW-1:0] window_speed_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  sliding_window_speed_statistic_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .speed_planar_i (speed_planar_i),
    .speed_full_i   (speed_full_i),
    .height_i       (height_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_speed_o (window_speed_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the sample stores and the configuration registers.
  logic [SpeedW-1:0] speed_hist [RingDepth];
  logic signed [HeightW-1:0] height_hist [RingDepth];
  logic [PtrW-1:0] hist_wr_ptr;
  logic [CfgDataW-1:0] window_frames_cfg;
  logic [1:0] stat_method_cfg;
  logic use_full_cfg;

  logic [SpeedW-1:0] expected_speeds [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // Stores one sample into the shadow rings and returns the statistic over
  // the newest window, scanned oldest first.
  function automatic logic [SpeedW-1:0] window_statistic(
    input logic [SpeedW-1:0] planar,
    input logic [SpeedW-1:0] full,
    input logic signed [HeightW-1:0] h
  );
    int unsigned n;
    int unsigned k;
    logic [PtrW-1:0] first;
    logic [PtrW-1:0] idx;
    logic [31:0] sum;
    logic [SpeedW-1:0] pick;
    logic signed [HeightW-1:0] top_height;
    speed_hist[hist_wr_ptr] = use_full_cfg ? full : planar;
    height_hist[hist_wr_ptr] = h;
    hist_wr_ptr = hist_wr_ptr + PtrW'(1);
    n = 32'(window_frames_cfg);
    if (n < 1) begin
      n = 1;
    end else if (n >= RingDepth) begin
      n = RingDepth - 1;
    end
    first = hist_wr_ptr - PtrW'(n);
    pick = speed_hist[first];
    top_height = height_hist[first];
    sum = 32'(speed_hist[first]);
    for (k = 1; k < n; k++) begin
      idx = first + PtrW'(k);
      case (stat_method_cfg)
        MethodAvg: begin
          sum = sum + 32'(speed_hist[idx]);
        end
        MethodMaxSpeed: begin
          if (speed_hist[idx] > pick) pick = speed_hist[idx];
        end
        // Only a strictly higher sample replaces the candidate, so the
        // oldest of equal heights is kept.
        MethodMaxHeight: begin
          if (height_hist[idx] > top_height) begin
            top_height = height_hist[idx];
            pick = speed_hist[idx];
          end
        end
        default: begin
          if (speed_hist[idx] < pick) pick = speed_hist[idx];
        end
      endcase
    end
    if (stat_method_cfg == MethodAvg) pick = SpeedW'(sum / n);
    return pick;
  endfunction

  // Receiver: stalls the output channel at the current rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker: every output transfer is matched with the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_speeds.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected window_speed: expected none, actual %h",
                 $time, window_speed_o);
      end else begin
        if (window_speed_o !== expected_speeds[0]) begin
          mismatch_count++;
          $display("%0t: window_speed mismatch: expected %h, actual %h",
                   $time, expected_speeds[0], window_speed_o);
        end
        void'(expected_speeds.pop_front());
      end
    end
  end

  // Hang detection: any transfer on any port restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, HangLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one sample, with random idle cycles ahead of it, and records the
  // expected statistic once the transfer happens. Valid stays high on return
  // so that back-to-back samples need no extra edge.
  task automatic send_sample(
    input logic [SpeedW-1:0] planar,
    input logic [SpeedW-1:0] full,
    input logic signed [HeightW-1:0] h
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    speed_planar_i <= planar;
    speed_full_i <= full;
    height_i <= h;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    expected_speeds.push_back(window_statistic(planar, full, h));
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic wait_idle(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Writes all three registers while the unit is idle.
  task automatic set_config(
    input logic [CfgDataW-1:0] frames,
    input logic [1:0] method,
    input logic full
  );
    wait_idle(PhaseSettle);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgWindowFrames;
    cfg_wdata_i <= frames;
    @(posedge clk_i);
    cfg_idx_i <= CfgStatMethod;
    cfg_wdata_i <= CfgDataW'(method);
    @(posedge clk_i);
    cfg_idx_i <= CfgUseFullSpeed;
    cfg_wdata_i <= CfgDataW'(full);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_frames_cfg = frames;
    stat_method_cfg = method;
    use_full_cfg = full;
  endtask

  function automatic logic [SpeedW-1:0] random_speed();
    case ($urandom_range(7))
      0: return '0;
      1: return SpeedMax;
      default: return SpeedW'($urandom);
    endcase
  endfunction

  // Reset values: a window of one under the average returns the sample.
  task automatic test_reset_defaults();
    send_sample(SpeedMax, '0, HeightMax);
    send_sample(24'h000001, 24'hABCDEF, HeightMin);
  endtask

  // Zero window acts as one; oversized windows clamp to depth minus one and
  // pull in entries that were never written.
  task automatic test_window_clamp();
    set_config(12'd0, MethodAvg, 1'b1);
    send_sample(24'h123456, SpeedMax, 25'sd7);
    set_config(12'd4095, MethodAvg, 1'b1);
    send_sample('0, SpeedMax, HeightMax);
    send_sample(SpeedMax, SpeedMax, HeightMin);
    set_config(12'd256, MethodMinSpeed, 1'b0);
    send_sample(SpeedMax, '0, '0);
    set_config(12'd255, MethodMaxSpeed, 1'b0);
    send_sample(24'h000100, SpeedMax, 25'sd1);
  endtask

  // Unwritten entries carry height zero, which beats negative samples.
  task automatic test_unwritten_heights();
    set_config(12'd4095, MethodMaxHeight, 1'b0);
    send_sample(SpeedMax, SpeedMax, HeightMin);
    send_sample(24'h00ABCD, SpeedMax, -25'sd1);
  endtask

  task automatic test_each_method();
    logic [2:0] m;
    for (m = 3'd0; m < 3'd4; m++) begin
      set_config(12'd3, m[1:0], m[0]);
      send_sample('0, SpeedMax, HeightMax);
      send_sample(SpeedMax, '0, HeightMin);
    end
  endtask

  // Equal maximal heights: the oldest of them supplies the speed.
  task automatic test_height_ties();
    set_config(12'd4, MethodMaxHeight, 1'b1);
    send_sample('0, 24'h000011, 25'sd100);
    send_sample('0, 24'h000022, 25'sd100);
    send_sample('0, 24'h000033, 25'sd100);
    send_sample('0, 24'h000044, 25'sd100);
    send_sample('0, 24'h000055, 25'sd100);
  endtask

  // Random samples under random settings, in three idle profiles. Each
  // change of setting first waits for the unit to drain completely.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned setting;
    int unsigned i;
    logic [CfgDataW-1:0] frames;
    logic signed [HeightW-1:0] h;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (setting = 0; setting < 5; setting++) begin
        // Mostly short windows, since the long ones take far longer per sample.
        case ($urandom_range(9))
          0: frames = '0;
          1: frames = '1;
          2: frames = CfgDataW'(RingDepth - 1);
          3: frames = CfgDataW'($urandom);
          default: frames = CfgDataW'($urandom_range(16, 1));
        endcase
        set_config(frames, 2'($urandom_range(3)), 1'($urandom_range(1)));
        for (i = 0; i < 30; i++) begin
          // A narrow band of heights makes ties common.
          case ($urandom_range(7))
            0, 1: h = HeightW'($signed($urandom_range(4)) - 2);
            2: h = HeightMin;
            3: h = HeightMax;
            default: h = HeightW'($urandom);
          endcase
          send_sample(random_speed(), random_speed(), h);
        end
      end
    end
  endtask

  initial begin
    for (int unsigned j = 0; j < RingDepth; j++) begin
      speed_hist[j] = '0;
      height_hist[j] = '0;
    end
    hist_wr_ptr = '0;
    window_frames_cfg = 12'd1;
    stat_method_cfg = MethodAvg;
    use_full_cfg = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 67;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_window_clamp();
    test_unwritten_heights();
    test_each_method();
    test_height_ties();
    test_random_traffic();

    wait_idle(EndSettle);
    if (mismatch_count == 0 && expected_speeds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sliding_window_speed_statistic_unit.f
rtl/swssu_pkg.sv
rtl/swssu_ram.sv
rtl/swssu_div.sv
rtl/sliding_window_speed_statistic_unit.sv
test/sliding_window_speed_statistic_unit_tb.sv
